// ===== hdl/itp_pkg.sv =====
`timescale 1ns / 1ps

package itp_pkg;

  // stack geometry
  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  // result kinds
  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  // error codes
  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_UNMATCHED = 2'd1,
    ERR_OVERFLOW  = 2'd2
  } err_t;

  // characters with a role of their own
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;

  // one result without its end-of-run flag
  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    err_t       err;
  } res_t;

  // request from the sequencer to the output stage
  typedef struct packed {
    logic push;    // hand over one result
    logic last;    // that result ends the run (pending slot must be empty)
    logic finish;  // close the run: the pending result gets last_of_run
    res_t res;
  } emit_req_t;

  // status from the output stage
  typedef struct packed {
    logic done;        // request taken this cycle
    logic out_free;    // output register can load this cycle
    logic pend_valid;  // a result waits in the pending slot
  } emit_sts_t;

endpackage

// ===== hdl/itp_in_if.sv =====
`timescale 1ns / 1ps

interface itp_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] in_char;

  modport source (output valid, output cmd, output in_char, input ready);
  modport sink (input valid, input cmd, input in_char, output ready);
endinterface

// ===== hdl/itp_out_if.sv =====
`timescale 1ns / 1ps

interface itp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_char;
  logic [1:0] error_code;
  logic       last_of_run;

  modport source (output valid, output kind, output out_char, output error_code,
                  output last_of_run, input ready);
  modport sink (input valid, input kind, input out_char, input error_code,
                input last_of_run, output ready);
endinterface

// ===== hdl/itp_ram.sv =====
`timescale 1ns / 1ps

module itp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/itp_out_stage.sv =====
`timescale 1ns / 1ps

module itp_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  itp_pkg::emit_req_t   req,
  output itp_pkg::emit_sts_t   sts,
  itp_out_if.source            out_ch
);

  logic          out_valid;
  itp_pkg::res_t out_res;
  logic          out_last;
  logic          pend_valid;
  itp_pkg::res_t pend_res;

  logic          out_free;
  logic          load_out;
  logic          load_from_pend;
  logic          load_last;
  logic          pend_load;
  logic          pend_clr;

  assign out_free = !out_valid || out_ch.ready;

  // route a request into the pending slot and the output register
  always_comb begin
    load_out       = 1'b0;
    load_from_pend = 1'b0;
    load_last      = 1'b0;
    pend_load      = 1'b0;
    pend_clr       = 1'b0;
    sts.done       = 1'b1;
    sts.out_free   = out_free;
    sts.pend_valid = pend_valid;
    if (req.push && !req.last) begin
      if (pend_valid) begin
        sts.done = out_free;
        if (out_free) begin
          load_out       = 1'b1;
          load_from_pend = 1'b1;
          pend_load      = 1'b1;
        end
      end else begin
        pend_load = 1'b1;
      end
    end else if (req.push) begin
      sts.done = out_free;
      if (out_free) begin
        load_out  = 1'b1;
        load_last = 1'b1;
      end
    end else if (req.finish && pend_valid) begin
      sts.done = out_free;
      if (out_free) begin
        load_out       = 1'b1;
        load_from_pend = 1'b1;
        load_last      = 1'b1;
        pend_clr       = 1'b1;
      end
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (pend_load) begin
        pend_valid <= 1'b1;
      end else if (pend_clr) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res  <= load_from_pend ? pend_res : req.res;
      out_last <= load_last;
    end
    if (pend_load) begin
      pend_res <= req.res;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.kind        = out_res.kind;
  assign out_ch.out_char    = out_res.ch;
  assign out_ch.error_code  = out_res.err;
  assign out_ch.last_of_run = out_last;

endmodule

// ===== hdl/infix_to_postfix_converter_unit.sv =====
`timescale 1ns / 1ps

// Infix-to-postfix converter by shunting-yard. Each input transfer carries one
// infix character or an end-of-expression command; each output transfer carries
// one postfix character, the end marker or an error, with last_of_run set on the
// final result of an input item. The operator stack lives in a 32 x 8 RAM with a
// registered read, so a character that needs no stack read (operand, space, '(',
// an operator onto an empty stack, an unmatched ')') is done in the idle state,
// while an operator over a non-empty stack, ')' and the end command read the
// stack one entry per cycle through the RAM read port, pausing whenever a
// result waits on the output ready. The pending slot in the output stage holds
// each popped result until the next one or the close of the run, so its
// end-of-run flag is known before it leaves. The stack needs no clearing after
// reset: only entries below the stack count are ever read.
module infix_to_postfix_converter_unit (
  input  logic      clk,
  input  logic      rst,
  itp_in_if.sink    in_ch,
  itp_out_if.source out_ch
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EVAL   = 5'b00010,
    ST_PUSH   = 5'b00100,
    ST_END    = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  typedef enum logic [2:0] {
    MODE_FLUSH = 3'b001,
    MODE_CLOSE = 3'b010,
    MODE_OPER  = 3'b100
  } mode_t;

  state_t                     state, state_next;
  mode_t                      mode, mode_next;
  logic [7:0]                 cur_char, cur_char_next;
  logic [itp_pkg::CNT_W-1:0]  count, count_next;
  logic [itp_pkg::CNT_W-1:0]  paren_cnt, paren_cnt_next;

  logic [itp_pkg::CNT_W-1:0]  top_m1;
  logic [itp_pkg::CNT_W-1:0]  top_m2;
  logic                       stk_full;
  logic                       in_accept;

  logic                       wr_en;
  logic [itp_pkg::ADDR_W-1:0] wr_addr;
  logic                       rd_en;
  logic [itp_pkg::ADDR_W-1:0] rd_addr;
  logic [7:0]                 rd_data;

  itp_pkg::emit_req_t         req;
  itp_pkg::emit_sts_t         sts;

  function automatic logic [1:0] prec(input logic [7:0] c);
    logic [1:0] p;
    case (c)
      itp_pkg::CH_CARET: p = 2'd3;
      itp_pkg::CH_STAR:  p = 2'd2;
      itp_pkg::CH_SLASH: p = 2'd2;
      itp_pkg::CH_PLUS:  p = 2'd1;
      itp_pkg::CH_MINUS: p = 2'd1;
      default:           p = 2'd0;
    endcase
    return p;
  endfunction

  assign top_m1    = count - itp_pkg::CNT_W'(1);
  assign top_m2    = count - itp_pkg::CNT_W'(2);
  assign stk_full  = count >= itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH);
  assign in_ch.ready = (state == ST_IDLE) && sts.out_free;
  assign in_accept = in_ch.valid && in_ch.ready;

  // stack RAM
  itp_ram #(
    .WIDTH (8),
    .DEPTH (itp_pkg::STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (cur_char_next),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // result register and pending slot
  itp_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .sts    (sts),
    .out_ch (out_ch)
  );

  // sequencer: read the top, decide, write back
  always_comb begin
    state_next     = state;
    mode_next      = mode;
    cur_char_next  = cur_char;
    count_next     = count;
    paren_cnt_next = paren_cnt;
    wr_en          = 1'b0;
    wr_addr        = count[itp_pkg::ADDR_W-1:0];
    rd_en          = 1'b0;
    rd_addr        = top_m1[itp_pkg::ADDR_W-1:0];
    req            = '0;
    req.res.kind   = itp_pkg::KIND_CHAR;
    req.res.err    = itp_pkg::ERR_NONE;

    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          cur_char_next = in_ch.in_char;
          if (in_ch.cmd) begin
            if (count == '0) begin
              state_next = ST_END;
            end else begin
              rd_en      = 1'b1;
              mode_next  = MODE_FLUSH;
              state_next = ST_EVAL;
            end
          end else begin
            case (in_ch.in_char)
              itp_pkg::CH_SPACE, itp_pkg::CH_TAB: begin
              end
              itp_pkg::CH_LPAREN: begin
                if (stk_full) begin
                  req.push     = 1'b1;
                  req.last     = 1'b1;
                  req.res.kind = itp_pkg::KIND_ERR;
                  req.res.err  = itp_pkg::ERR_OVERFLOW;
                end else begin
                  wr_en          = 1'b1;
                  count_next     = count + itp_pkg::CNT_W'(1);
                  paren_cnt_next = paren_cnt + itp_pkg::CNT_W'(1);
                end
              end
              itp_pkg::CH_RPAREN: begin
                if (paren_cnt == '0) begin
                  count_next   = '0;
                  req.push     = 1'b1;
                  req.last     = 1'b1;
                  req.res.kind = itp_pkg::KIND_ERR;
                  req.res.err  = itp_pkg::ERR_UNMATCHED;
                end else begin
                  rd_en      = 1'b1;
                  mode_next  = MODE_CLOSE;
                  state_next = ST_EVAL;
                end
              end
              itp_pkg::CH_CARET, itp_pkg::CH_STAR, itp_pkg::CH_SLASH,
              itp_pkg::CH_PLUS, itp_pkg::CH_MINUS: begin
                if (count == '0) begin
                  wr_en      = 1'b1;
                  count_next = itp_pkg::CNT_W'(1);
                end else begin
                  rd_en      = 1'b1;
                  mode_next  = MODE_OPER;
                  state_next = ST_EVAL;
                end
              end
              default: begin
                req.push   = 1'b1;
                req.last   = 1'b1;
                req.res.ch = in_ch.in_char;
              end
            endcase
          end
        end
      end

      ST_EVAL: begin
        req.res.ch = rd_data;
        case (mode)
          MODE_FLUSH: begin
            req.push = 1'b1;
            if (sts.done) begin
              count_next = top_m1;
              if (rd_data == itp_pkg::CH_LPAREN) begin
                paren_cnt_next = paren_cnt - itp_pkg::CNT_W'(1);
              end
              if (top_m1 == '0) begin
                state_next = ST_END;
              end else begin
                rd_en   = 1'b1;
                rd_addr = top_m2[itp_pkg::ADDR_W-1:0];
              end
            end
          end
          MODE_CLOSE: begin
            if (rd_data == itp_pkg::CH_LPAREN) begin
              count_next     = top_m1;
              paren_cnt_next = paren_cnt - itp_pkg::CNT_W'(1);
              state_next     = ST_FINISH;
            end else begin
              req.push = 1'b1;
              if (sts.done) begin
                count_next = top_m1;
                rd_en      = 1'b1;
                rd_addr    = top_m2[itp_pkg::ADDR_W-1:0];
              end
            end
          end
          MODE_OPER: begin
            if (prec(rd_data) >= prec(cur_char)) begin
              req.push = 1'b1;
              if (sts.done) begin
                count_next = top_m1;
                if (top_m1 == '0) begin
                  state_next = ST_PUSH;
                end else begin
                  rd_en   = 1'b1;
                  rd_addr = top_m2[itp_pkg::ADDR_W-1:0];
                end
              end
            end else begin
              state_next = ST_PUSH;
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end

      ST_PUSH: begin
        if (stk_full) begin
          req.push     = 1'b1;
          req.res.kind = itp_pkg::KIND_ERR;
          req.res.err  = itp_pkg::ERR_OVERFLOW;
          if (sts.done) begin
            state_next = ST_FINISH;
          end
        end else begin
          wr_en      = 1'b1;
          count_next = count + itp_pkg::CNT_W'(1);
          state_next = ST_FINISH;
        end
      end

      ST_END: begin
        req.push     = 1'b1;
        req.res.kind = itp_pkg::KIND_END;
        if (sts.done) begin
          state_next = ST_FINISH;
        end
      end

      ST_FINISH: begin
        req.finish = 1'b1;
        if (sts.done) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mode      <= MODE_FLUSH;
      count     <= '0;
      paren_cnt <= '0;
    end else begin
      state     <= state_next;
      mode      <= mode_next;
      count     <= count_next;
      paren_cnt <= paren_cnt_next;
    end
  end

  // current character
  always_ff @(posedge clk) begin
    cur_char <= cur_char_next;
  end

  // stack occupancy stays in range, open parentheses are a subset of it
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH) && paren_cnt <= count)
    else $error("stack count out of range");

  // between items no result may be left waiting in the pending slot
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !sts.pend_valid)
    else $error("pending result left behind at idle");

  // error and end results always close their run and carry no character
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && (out_ch.kind == itp_pkg::KIND_ERR || out_ch.kind == itp_pkg::KIND_END)
    |-> out_ch.last_of_run && out_ch.out_char == 8'd0)
    else $error("error or end result not last or with a character");

  // a stack read is only issued when entries are stacked
  a_read_nonempty: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> count != '0)
    else $error("stack read while empty");

endmodule

// ===== verif/infix_to_postfix_converter_unit_tb.sv =====
`timescale 1ns / 1ps

module infix_to_postfix_converter_unit_tb;

  // one input transfer
  typedef struct packed {
    logic       cmd;
    logic [7:0] ch;
  } infix_t;

  // one output transfer as predicted
  typedef struct packed {
    itp_pkg::kind_t kind;
    logic [7:0]     ch;
    itp_pkg::err_t  err;
    logic           last_flag;
  } postfix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  itp_in_if  in_bus ();
  itp_out_if out_bus ();

  infix_to_postfix_converter_unit dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  always #10 clk = ~clk;

  // characters still to send, predicted postfix output, failures seen
  infix_t      pending_q [$];
  postfix_t    postfix_q [$];
  postfix_t    run_q [$];
  int unsigned fail_cnt = 0;
  int unsigned n_stim = 0;

  // operator stack mirror
  logic [7:0] op_stack [itp_pkg::STACK_DEPTH];
  int         op_depth = 0;

  // precedence, zero for anything that is not an operator
  function automatic int unsigned op_rank(logic [7:0] c);
    case (c)
      itp_pkg::CH_CARET:                    return 3;
      itp_pkg::CH_STAR, itp_pkg::CH_SLASH:  return 2;
      itp_pkg::CH_PLUS, itp_pkg::CH_MINUS:  return 1;
      default:                              return 0;
    endcase
  endfunction

  function automatic postfix_t make_res(itp_pkg::kind_t k, logic [7:0] c,
                                        itp_pkg::err_t e);
    postfix_t r;
    r.kind      = k;
    r.ch        = c;
    r.err       = e;
    r.last_flag = 1'b0;
    return r;
  endfunction

  // push, or flag overflow and drop the character
  task automatic stack_or_overflow(input logic [7:0] c);
    if (op_depth >= itp_pkg::STACK_DEPTH) begin
      run_q.push_back(make_res(itp_pkg::KIND_ERR, 8'h00, itp_pkg::ERR_OVERFLOW));
    end else begin
      op_stack[op_depth] = c;
      op_depth++;
    end
  endtask

  // shunting-yard step for one accepted character or end command
  task automatic shunt_item(input infix_t it);
    postfix_t   r;
    logic [7:0] top;
    bit         has_open;
    int         i;
    run_q.delete();
    if (it.cmd) begin
      while (op_depth > 0) begin
        op_depth--;
        run_q.push_back(make_res(itp_pkg::KIND_CHAR, op_stack[op_depth],
                                 itp_pkg::ERR_NONE));
      end
      run_q.push_back(make_res(itp_pkg::KIND_END, 8'h00, itp_pkg::ERR_NONE));
    end else if (it.ch == itp_pkg::CH_SPACE || it.ch == itp_pkg::CH_TAB) begin
      // whitespace gives nothing
    end else if (it.ch == itp_pkg::CH_LPAREN) begin
      stack_or_overflow(it.ch);
    end else if (it.ch == itp_pkg::CH_RPAREN) begin
      has_open = 1'b0;
      for (i = 0; i < op_depth; i++)
        if (op_stack[i] == itp_pkg::CH_LPAREN) has_open = 1'b1;
      if (!has_open) begin
        op_depth = 0;
        run_q.push_back(make_res(itp_pkg::KIND_ERR, 8'h00, itp_pkg::ERR_UNMATCHED));
      end else begin
        op_depth--;
        top = op_stack[op_depth];
        while (top != itp_pkg::CH_LPAREN) begin
          run_q.push_back(make_res(itp_pkg::KIND_CHAR, top, itp_pkg::ERR_NONE));
          op_depth--;
          top = op_stack[op_depth];
        end
      end
    end else if (op_rank(it.ch) != 0) begin
      while (op_depth > 0 && op_rank(op_stack[op_depth - 1]) >= op_rank(it.ch)) begin
        op_depth--;
        run_q.push_back(make_res(itp_pkg::KIND_CHAR, op_stack[op_depth],
                                 itp_pkg::ERR_NONE));
      end
      stack_or_overflow(it.ch);
    end else begin
      run_q.push_back(make_res(itp_pkg::KIND_CHAR, it.ch, itp_pkg::ERR_NONE));
    end
    // mark the final result of this item
    for (i = 0; i < run_q.size(); i++) begin
      r = run_q[i];
      r.last_flag = (i == run_q.size() - 1);
      postfix_q.push_back(r);
    end
  endtask

  // stimulus builders
  task automatic add_char(input logic [7:0] c);
    infix_t it;
    it.cmd = 1'b0;
    it.ch  = c;
    pending_q.push_back(it);
    n_stim++;
  endtask

  task automatic add_end();
    infix_t it;
    it.cmd = 1'b1;
    it.ch  = 8'($urandom_range(0, 255));
    pending_q.push_back(it);
    n_stim++;
  endtask

  function automatic logic [7:0] rand_operand();
    case ($urandom_range(0, 2))
      0:       return 8'("a" + $urandom_range(0, 25));
      1:       return 8'("A" + $urandom_range(0, 25));
      default: return 8'("0" + $urandom_range(0, 9));
    endcase
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(0, 4))
      0:       return itp_pkg::CH_PLUS;
      1:       return itp_pkg::CH_MINUS;
      2:       return itp_pkg::CH_STAR;
      3:       return itp_pkg::CH_SLASH;
      default: return itp_pkg::CH_CARET;
    endcase
  endfunction

  function automatic logic [7:0] rand_blank();
    return ($urandom_range(0, 1) != 0) ? itp_pkg::CH_SPACE : itp_pkg::CH_TAB;
  endfunction

  // balanced expression with random operands, operators and nesting
  task automatic add_expr(input int unsigned max_nest);
    int unsigned n_opnd, depth, k, i;
    n_opnd = $urandom_range(1, 8);
    depth  = 0;
    for (i = 0; i < n_opnd; i++) begin
      k = $urandom_range(0, 2);
      while (k != 0 && depth < max_nest) begin
        add_char(itp_pkg::CH_LPAREN);
        depth++;
        k--;
      end
      add_char(rand_operand());
      if ($urandom_range(0, 5) == 0) add_char(rand_blank());
      k = $urandom_range(0, depth);
      while (k != 0) begin
        add_char(itp_pkg::CH_RPAREN);
        depth--;
        k--;
      end
      if (i != n_opnd - 1) add_char(rand_op());
    end
    while (depth != 0) begin
      add_char(itp_pkg::CH_RPAREN);
      depth--;
    end
    add_end();
  endtask

  // broken token soup, end command only sometimes
  task automatic add_jumble();
    int unsigned n, i;
    n = $urandom_range(3, 12);
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0:       add_char(itp_pkg::CH_LPAREN);
        1:       add_char(itp_pkg::CH_RPAREN);
        2, 3:    add_char(rand_operand());
        4:       add_char(rand_op());
        default: add_char(rand_blank());
      endcase
    end
    if ($urandom_range(0, 1) != 0) add_end();
  endtask

  // deep nesting that drives the stack toward or past full
  task automatic add_deep_nest(input int unsigned lo);
    int unsigned n, i;
    n = $urandom_range(lo, 38);
    for (i = 0; i < n; i++) begin
      add_char(itp_pkg::CH_LPAREN);
      if ($urandom_range(0, 3) == 0) add_char(rand_op());
      else if ($urandom_range(0, 2) == 0) add_char(rand_operand());
    end
    case ($urandom_range(0, 2))
      0: add_char(rand_op());
      1: begin
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) begin
          add_char(rand_operand());
          add_char(itp_pkg::CH_RPAREN);
        end
      end
      default: ;
    endcase
    add_end();
  endtask

  // sender: bursts with random gaps, holds an offered item until its transfer
  int unsigned burst_left, gap_left;

  always @(posedge clk) begin : tx_drive
    if (rst) begin
      in_bus.valid   <= 1'b0;
      in_bus.cmd     <= 1'b0;
      in_bus.in_char <= 8'h00;
      burst_left     <= 0;
      gap_left       <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        shunt_item(pending_q[0]);
        void'(pending_q.pop_front());
      end
      if (in_bus.valid && !in_bus.ready) begin
        // keep offering the same item
      end else if (gap_left != 0) begin
        gap_left     <= gap_left - 1;
        in_bus.valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        in_bus.valid   <= 1'b1;
        in_bus.cmd     <= pending_q[0].cmd;
        in_bus.in_char <= pending_q[0].ch;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 20);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // receiver: windowed stall pattern plus two long hold-offs
  int unsigned rx_seen, hold_left, win_left, stall_period, stall_len, stall_phase;

  always @(posedge clk) begin : rx_pace
    int unsigned p;
    if (rst) begin
      out_bus.ready <= 1'b0;
      rx_seen       <= 0;
      hold_left     <= 0;
      win_left      <= 0;
      stall_period  <= 1;
      stall_len     <= 0;
      stall_phase   <= 0;
    end else begin
      if (out_bus.valid && out_bus.ready) rx_seen <= rx_seen + 1;
      if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        out_bus.ready <= 1'b0;
      end else if (out_bus.valid && out_bus.ready && (rx_seen == 60 || rx_seen == 350)) begin
        // block fills up and must stall its input
        hold_left     <= 400;
        out_bus.ready <= 1'b0;
      end else begin
        if (win_left == 0) begin
          p            = $urandom_range(2, 9);
          win_left     <= $urandom_range(50, 250);
          stall_period <= p;
          stall_len    <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, p - 1);
          stall_phase  <= 0;
        end else begin
          win_left    <= win_left - 1;
          stall_phase <= (stall_phase + 1 >= stall_period) ? 0 : stall_phase + 1;
        end
        out_bus.ready <= (stall_phase >= stall_len);
      end
    end
  end

  // compare each output transfer with the oldest prediction
  always @(posedge clk) begin : rx_check
    postfix_t want;
    if (!rst && out_bus.valid && out_bus.ready) begin
      if (postfix_q.size() == 0) begin
        $error("unexpected result: kind %0d, out_char %02h, error_code %0d",
               out_bus.kind, out_bus.out_char, out_bus.error_code);
        fail_cnt++;
      end else begin
        want = postfix_q.pop_front();
        if (out_bus.kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, out_bus.kind);
          fail_cnt++;
        end
        if (out_bus.out_char !== want.ch) begin
          $error("out_char: expected %02h, actual %02h", want.ch, out_bus.out_char);
          fail_cnt++;
        end
        if (out_bus.error_code !== want.err) begin
          $error("error_code: expected %0d, actual %0d", want.err, out_bus.error_code);
          fail_cnt++;
        end
        if (out_bus.last_of_run !== want.last_flag) begin
          $error("last_of_run: expected %0d, actual %0d", want.last_flag,
                 out_bus.last_of_run);
          fail_cnt++;
        end
      end
    end
  end

  // stimulus, reset and end of run
  initial begin : main_seq
    int unsigned r;

    // operand extremes and whitespace
    add_char(8'h00);
    add_char(8'hFF);
    add_char(8'h80);
    add_char(itp_pkg::CH_SPACE);
    add_char(itp_pkg::CH_TAB);
    // every operator but minus, nesting, left-associative caret
    add_char(itp_pkg::CH_LPAREN);
    add_char("a");
    add_char(itp_pkg::CH_PLUS);
    add_char("b");
    add_char(itp_pkg::CH_STAR);
    add_char("c");
    add_char(itp_pkg::CH_CARET);
    add_char("d");
    add_char(itp_pkg::CH_CARET);
    add_char(itp_pkg::CH_SLASH);
    add_char(itp_pkg::CH_RPAREN);
    // unmatched close clears a stacked operator
    add_char(itp_pkg::CH_MINUS);
    add_char(itp_pkg::CH_RPAREN);
    // leftover open paren is flushed by the end command
    add_char(itp_pkg::CH_LPAREN);
    add_char(itp_pkg::CH_STAR);
    add_end();
    // end command on an empty stack
    add_end();

    // random part: forced overflow first, then a mix of segments
    add_deep_nest(34);
    while (n_stim < 425) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        add_expr($urandom_range(0, 5));
      end else if (r < 70) begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 7) == 0) add_end();
          else add_char(8'($urandom_range(0, 255)));
        end
      end else if (r < 88) begin
        add_jumble();
      end else begin
        add_deep_nest(20);
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // wait for every transfer in and every prediction matched
    while (pending_q.size() != 0 || postfix_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);

    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
